>>> src/jbt_pkg.sv
// Package: shared types and constants for the JSON byte tokenizer.
package jbt_pkg;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_STR    = 4'd1,
        M_ESC    = 4'd2,
        M_HEX    = 4'd3,
        M_KWT    = 4'd4,
        M_KWF    = 4'd5,
        M_KWN    = 4'd6,
        M_NUM    = 4'd7,
        M_NUMBAD = 4'd8,
        M_FROZEN = 4'd9
    } t_mode;

    localparam logic [3:0] K_LBRACE = 4'd0;
    localparam logic [3:0] K_RBRACE = 4'd1;
    localparam logic [3:0] K_LBRACK = 4'd2;
    localparam logic [3:0] K_RBRACK = 4'd3;
    localparam logic [3:0] K_COMMA  = 4'd4;
    localparam logic [3:0] K_COLON  = 4'd5;
    localparam logic [3:0] K_STRING = 4'd6;
    localparam logic [3:0] K_NUMBER = 4'd7;
    localparam logic [3:0] K_TRUE   = 4'd8;

    localparam logic [2:0] E_UNTERM  = 3'd0;
    localparam logic [2:0] E_UNICODE = 3'd1;
    localparam logic [2:0] E_HEX     = 3'd2;
    localparam logic [2:0] E_KEYWORD = 3'd3;
    localparam logic [2:0] E_NUMBER  = 3'd4;
    localparam logic [2:0] E_CHAR    = 3'd5;

    localparam int unsigned MAX_RES = 6;
    localparam logic [4:0] KW_BAD = 5'd31;

    // Number flag bits.
    localparam int unsigned NF_ESEEN    = 0;
    localparam int unsigned NF_LASTE    = 1;
    localparam int unsigned NF_LASTSIGN = 2;
    localparam int unsigned NF_LEADDOT  = 3;

    typedef struct packed {
        logic [3:0]  kind;
        logic        has_byte;
        logic [7:0]  pbyte;
        logic        done;
        logic        err;
        logic [2:0]  code;
        logic [15:0] line;
        logic [15:0] col;
    } t_result;

    // Expected letter of keyword k (0 true, 1 false, 2 null) at position p.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [4:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0: case (p)
                5'd0: c = "t"; 5'd1: c = "r"; 5'd2: c = "u"; 5'd3: c = "e";
                default: c = 8'h00;
            endcase
            2'd1: case (p)
                5'd0: c = "f"; 5'd1: c = "a"; 5'd2: c = "l"; 5'd3: c = "s";
                5'd4: c = "e";
                default: c = 8'h00;
            endcase
            2'd2: case (p)
                5'd0: c = "n"; 5'd1: c = "u"; 5'd2: c = "l"; 5'd3: c = "l";
                default: c = 8'h00;
            endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] kw_len(input logic [1:0] k);
        logic [4:0] n;
        case (k)
            2'd1:    n = 5'd5;
            default: n = 5'd4;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= "0" && c <= "9")      v = {1'b0, c[3:0]};
        else if (c >= "a" && c <= "f") v = {1'b0, c[3:0] + 4'd9};
        else if (c >= "A" && c <= "F") v = {1'b0, c[3:0] + 4'd9};
        else                           v = 5'b10000;
        return v;
    endfunction

endpackage

>>> src/json_byte_tokenizer_top.sv
// Top level: JSON byte lexer with UTF-8 escape decoding and a result queue.
// Results are registered: a result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle while i_stall is low and no byte yields more than one
//   result; a byte that yields several results (up to 4) stalls input until its last one leaves.
// Reset (i_rst_n low, synchronous): lexer idle, line 1 column 1, no results pending.
// End of text closes the pending token and returns the lexer to its reset state.
module json_byte_tokenizer_top #(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic        o_has_byte,
    output logic [7:0]  o_payload_byte,
    output logic        o_token_done,
    output logic        o_error_flag,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column_number,
    output logic        o_last_of_run
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // Lexer state.
    jbt_pkg::t_mode            r_mode, n_mode;
    logic [15:0]               r_hacc, n_hacc;
    logic [2:0]                r_hcnt, n_hcnt;
    logic [9:0]                r_hsur, n_hsur;
    logic [1:0]                r_spend, n_spend;
    logic [4:0]                r_kwp, n_kwp;
    logic [3:0]                r_nf, n_nf;
    logic [POSITION_BITS-1:0]  r_line, n_line;
    logic [POSITION_BITS-1:0]  r_col, n_col;

    // Result burst buffer: holds the results of one transaction; slot 0 is shown.
    jbt_pkg::t_result r_res [jbt_pkg::MAX_RES];
    logic [2:0]       r_cnt;
    jbt_pkg::t_result n_res [jbt_pkg::MAX_RES];
    logic [2:0]       n_cnt;

    logic accept, pop;

    // Take a new byte once the buffer is empty or its last result leaves now.
    assign pop     = (r_cnt != 3'd0) && !i_stall;
    assign o_stall = !((r_cnt == 3'd0) || (r_cnt == 3'd1 && !i_stall));
    assign accept  = i_valid && !o_stall;

    // Combinational lexer step.
    always_comb begin
        logic [7:0]  c;
        logic        live;
        logic [1:0]  k;
        logic [4:0]  hv;
        logic [15:0] cp;
        logic [20:0] cp4;
        logic        bad;
        logic [3:0]  f;
        logic [15:0] pl, pc;
        jbt_pkg::t_result r;

        c = i_text_byte;
        n_mode = r_mode; n_hacc = r_hacc; n_hcnt = r_hcnt; n_hsur = r_hsur;
        n_spend = r_spend; n_kwp = r_kwp; n_nf = r_nf; n_line = r_line; n_col = r_col;
        n_cnt = 3'd0;
        for (int i = 0; i < jbt_pkg::MAX_RES; i++) n_res[i] = '0;
        live = 1'b1;
        k = 2'd0; hv = '0; cp = '0; cp4 = '0; bad = 1'b0; f = '0;
        pl = 16'(r_line); pc = 16'(r_col);
        r = '0;

        if (i_end_of_text) begin
            r = '0; r.line = pl; r.col = pc;
            if (r_mode == jbt_pkg::M_STR || r_mode == jbt_pkg::M_ESC ||
                r_mode == jbt_pkg::M_HEX) begin
                r.err = 1'b1; r.code = jbt_pkg::E_UNTERM;
                n_res[0] = r; n_cnt = 3'd1;
            end else if (r_mode == jbt_pkg::M_KWT || r_mode == jbt_pkg::M_KWF ||
                         r_mode == jbt_pkg::M_KWN) begin
                k = 2'(r_mode - jbt_pkg::M_KWT);
                if (r_kwp == jbt_pkg::kw_len(k)) begin
                    r.kind = jbt_pkg::K_TRUE + {2'b00, k}; r.done = 1'b1;
                end else begin
                    r.err = 1'b1; r.code = jbt_pkg::E_KEYWORD;
                end
                n_res[0] = r; n_cnt = 3'd1;
            end else if (r_mode == jbt_pkg::M_NUM || r_mode == jbt_pkg::M_NUMBAD) begin
                if (r_mode == jbt_pkg::M_NUMBAD || r_nf[2:1] != 2'b00 ||
                    r_nf[jbt_pkg::NF_LEADDOT]) begin
                    r.err = 1'b1; r.code = jbt_pkg::E_NUMBER;
                end else begin
                    r.kind = jbt_pkg::K_NUMBER; r.done = 1'b1;
                end
                n_res[0] = r; n_cnt = 3'd1;
            end
            n_mode = jbt_pkg::M_IDLE; n_hacc = '0; n_hcnt = '0; n_hsur = '0;
            n_spend = '0; n_kwp = '0; n_nf = '0; n_line = POS_ONE; n_col = POS_ONE;
        end else if (r_mode != jbt_pkg::M_FROZEN) begin
            // Keyword continuation or close.
            if (r_mode == jbt_pkg::M_KWT || r_mode == jbt_pkg::M_KWF ||
                r_mode == jbt_pkg::M_KWN) begin
                k = 2'(r_mode - jbt_pkg::M_KWT);
                if (c >= "a" && c <= "z") begin
                    live = 1'b0;
                    if (r_kwp < jbt_pkg::kw_len(k) && jbt_pkg::kw_char(k, r_kwp) == c)
                        n_kwp = r_kwp + 5'd1;
                    else
                        n_kwp = jbt_pkg::KW_BAD;
                end else begin
                    r = '0; r.line = pl; r.col = pc;
                    if (r_kwp == jbt_pkg::kw_len(k)) begin
                        r.kind = jbt_pkg::K_TRUE + {2'b00, k}; r.done = 1'b1;
                        n_mode = jbt_pkg::M_IDLE;
                    end else begin
                        r.err = 1'b1; r.code = jbt_pkg::E_KEYWORD;
                        n_mode = jbt_pkg::M_FROZEN;
                    end
                    n_kwp = '0;
                    n_res[0] = r; n_cnt = 3'd1;
                end
            end else if (r_mode == jbt_pkg::M_NUM || r_mode == jbt_pkg::M_NUMBAD) begin
                if ((c >= "0" && c <= "9") || c == "-" || c == "+" || c == "." ||
                    c == "e" || c == "E") begin
                    live = 1'b0;
                    f = r_nf;
                    if (f[jbt_pkg::NF_LEADDOT]) begin
                        if (c >= "0" && c <= "9") f = '0; else bad = 1'b1;
                    end else if (c >= "0" && c <= "9") begin
                        f[2:1] = 2'b00;
                    end else if (c == ".") begin
                        if (f[jbt_pkg::NF_ESEEN]) bad = 1'b1;
                        f[2:1] = 2'b00;
                    end else if (c == "e") begin
                        f[jbt_pkg::NF_ESEEN] = 1'b1; f[jbt_pkg::NF_LASTE] = 1'b1;
                        f[jbt_pkg::NF_LASTSIGN] = 1'b0;
                    end else if (c == "+" || c == "-") begin
                        if (f[jbt_pkg::NF_LASTE]) begin
                            f[jbt_pkg::NF_LASTE] = 1'b0; f[jbt_pkg::NF_LASTSIGN] = 1'b1;
                        end else bad = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                    n_nf = f;
                    if (bad) n_mode = jbt_pkg::M_NUMBAD;
                end else begin
                    r = '0; r.line = pl; r.col = pc;
                    if (r_mode == jbt_pkg::M_NUMBAD || r_nf[2:1] != 2'b00 ||
                        r_nf[jbt_pkg::NF_LEADDOT]) begin
                        r.err = 1'b1; r.code = jbt_pkg::E_NUMBER;
                        n_mode = jbt_pkg::M_FROZEN;
                    end else begin
                        r.kind = jbt_pkg::K_NUMBER; r.done = 1'b1;
                        n_mode = jbt_pkg::M_IDLE;
                    end
                    n_nf = '0;
                    n_res[0] = r; n_cnt = 3'd1;
                end
            end

            // Advance position for the consumed byte.
            if (n_mode != jbt_pkg::M_FROZEN) begin
                if (c == 8'h0A) begin
                    if (r_line != POS_MAX) n_line = r_line + POS_ONE;
                    n_col = '0;
                end else if (r_col != POS_MAX) begin
                    n_col = r_col + POS_ONE;
                end
            end
            pl = 16'(n_line); pc = 16'(n_col);

            if (!live) begin
                // Number payload byte when still in a number.
                if (r_mode == jbt_pkg::M_NUM || r_mode == jbt_pkg::M_NUMBAD) begin
                    r = '0; r.line = pl; r.col = pc;
                    r.kind = jbt_pkg::K_NUMBER; r.has_byte = 1'b1; r.pbyte = c;
                    n_res[0] = r; n_cnt = 3'd1;
                end
            end else if (n_mode == jbt_pkg::M_IDLE) begin
                r = '0; r.line = pl; r.col = pc; r.done = 1'b1;
                case (c)
                    "{": begin r.kind = jbt_pkg::K_LBRACE; n_res[n_cnt] = r; n_cnt++; end
                    "}": begin r.kind = jbt_pkg::K_RBRACE; n_res[n_cnt] = r; n_cnt++; end
                    "[": begin r.kind = jbt_pkg::K_LBRACK; n_res[n_cnt] = r; n_cnt++; end
                    "]": begin r.kind = jbt_pkg::K_RBRACK; n_res[n_cnt] = r; n_cnt++; end
                    ",": begin r.kind = jbt_pkg::K_COMMA;  n_res[n_cnt] = r; n_cnt++; end
                    ":": begin r.kind = jbt_pkg::K_COLON;  n_res[n_cnt] = r; n_cnt++; end
                    "\"": begin
                        n_mode = jbt_pkg::M_STR; n_spend = '0; n_hsur = '0;
                        n_hacc = '0; n_hcnt = '0;
                    end
                    "t": begin n_mode = jbt_pkg::M_KWT; n_kwp = 5'd1; end
                    "f": begin n_mode = jbt_pkg::M_KWF; n_kwp = 5'd1; end
                    "n": begin n_mode = jbt_pkg::M_KWN; n_kwp = 5'd1; end
                    " ", 8'h0A: begin end
                    default: begin
                        if (c == "." || (c >= "0" && c <= "9")) begin
                            n_mode = jbt_pkg::M_NUM;
                            n_nf = (c == ".") ? 4'b1000 : 4'b0000;
                            r.done = 1'b0; r.kind = jbt_pkg::K_NUMBER;
                            r.has_byte = 1'b1; r.pbyte = c;
                        end else begin
                            r = '0; r.line = pl; r.col = pc;
                            r.err = 1'b1; r.code = jbt_pkg::E_CHAR;
                            n_mode = jbt_pkg::M_FROZEN;
                        end
                        n_res[n_cnt] = r; n_cnt++;
                    end
                endcase
            end else if (n_mode != jbt_pkg::M_FROZEN) begin
                // String handling.
                r = '0; r.line = pl; r.col = pc; r.kind = jbt_pkg::K_STRING;
                if (r_mode == jbt_pkg::M_HEX) begin
                    hv = jbt_pkg::hex_val(c);
                    if (hv[4]) begin
                        r = '0; r.line = pl; r.col = pc; r.err = 1'b1;
                        r.code = (c == "\"") ? jbt_pkg::E_UNICODE : jbt_pkg::E_HEX;
                        n_mode = jbt_pkg::M_FROZEN;
                        n_res[0] = r; n_cnt = 3'd1;
                    end else if (r_hcnt != 3'd3) begin
                        n_hacc = {r_hacc[11:0], hv[3:0]};
                        n_hcnt = r_hcnt + 3'd1;
                    end else begin
                        cp = {r_hacc[11:0], hv[3:0]};
                        n_hacc = '0; n_hcnt = '0; n_mode = jbt_pkg::M_STR;
                        r.has_byte = 1'b1;
                        if (r_spend == 2'd3) begin
                            if (cp[15:10] == 6'b110111) begin
                                cp4 = 21'h10000 + {1'b0, r_hsur, cp[9:0]};
                                r.pbyte = {5'b11110, cp4[20:18]}; n_res[0] = r;
                                r.pbyte = {2'b10, cp4[17:12]};    n_res[1] = r;
                                r.pbyte = {2'b10, cp4[11:6]};     n_res[2] = r;
                                r.pbyte = {2'b10, cp4[5:0]};      n_res[3] = r;
                                n_cnt = 3'd4; n_spend = '0; n_hsur = '0;
                            end else begin
                                r = '0; r.line = pl; r.col = pc; r.err = 1'b1;
                                r.code = jbt_pkg::E_UNICODE;
                                n_mode = jbt_pkg::M_FROZEN;
                                n_res[0] = r; n_cnt = 3'd1;
                            end
                        end else if (cp[15:10] == 6'b110110) begin
                            n_hsur = cp[9:0]; n_spend = 2'd1;
                        end else if (cp[15:10] == 6'b110111) begin
                            r = '0; r.line = pl; r.col = pc; r.err = 1'b1;
                            r.code = jbt_pkg::E_UNICODE;
                            n_mode = jbt_pkg::M_FROZEN;
                            n_res[0] = r; n_cnt = 3'd1;
                        end else if (cp <= 16'h007F) begin
                            r.pbyte = cp[7:0]; n_res[0] = r; n_cnt = 3'd1;
                        end else if (cp <= 16'h07FF) begin
                            r.pbyte = {3'b110, cp[10:6]}; n_res[0] = r;
                            r.pbyte = {2'b10, cp[5:0]};   n_res[1] = r;
                            n_cnt = 3'd2;
                        end else begin
                            r.pbyte = {4'b1110, cp[15:12]}; n_res[0] = r;
                            r.pbyte = {2'b10, cp[11:6]};    n_res[1] = r;
                            r.pbyte = {2'b10, cp[5:0]};     n_res[2] = r;
                            n_cnt = 3'd3;
                        end
                    end
                end else if (r_mode == jbt_pkg::M_ESC) begin
                    if (c == "u") begin
                        n_mode = jbt_pkg::M_HEX; n_hacc = '0; n_hcnt = '0;
                    end else begin
                        r.has_byte = 1'b1;
                        r.pbyte = "\\"; n_res[0] = r;
                        r.pbyte = c;    n_res[1] = r;
                        n_cnt = 3'd2; n_mode = jbt_pkg::M_STR;
                    end
                end else if (r_spend == 2'd1 || r_spend == 2'd2) begin
                    if (r_spend == 2'd1 && c == "\\") begin
                        n_spend = 2'd2;
                    end else if (r_spend == 2'd2 && c == "u") begin
                        n_spend = 2'd3; n_mode = jbt_pkg::M_HEX;
                        n_hacc = '0; n_hcnt = '0;
                    end else begin
                        r = '0; r.line = pl; r.col = pc; r.err = 1'b1;
                        r.code = jbt_pkg::E_UNICODE;
                        n_mode = jbt_pkg::M_FROZEN;
                        n_res[0] = r; n_cnt = 3'd1;
                    end
                end else if (c == "\\") begin
                    n_mode = jbt_pkg::M_ESC;
                end else if (c == "\"") begin
                    r.done = 1'b1; n_mode = jbt_pkg::M_IDLE;
                    n_res[0] = r; n_cnt = 3'd1;
                end else begin
                    r.has_byte = 1'b1; r.pbyte = c;
                    n_res[0] = r; n_cnt = 3'd1;
                end
            end
        end
    end

    // State and burst buffer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jbt_pkg::M_IDLE; r_hacc <= '0; r_hcnt <= '0; r_hsur <= '0;
            r_spend <= '0; r_kwp <= '0; r_nf <= '0;
            r_line <= POS_ONE; r_col <= POS_ONE;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_mode <= n_mode; r_hacc <= n_hacc; r_hcnt <= n_hcnt; r_hsur <= n_hsur;
                r_spend <= n_spend; r_kwp <= n_kwp; r_nf <= n_nf;
                r_line <= n_line; r_col <= n_col;
                r_cnt <= n_cnt;
            end else if (pop) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    // Payload of the buffer: load a whole burst, or shift one slot on each pop.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < jbt_pkg::MAX_RES; i++) r_res[i] <= n_res[i];
        end else if (pop) begin
            for (int i = 0; i < jbt_pkg::MAX_RES - 1; i++) r_res[i] <= r_res[i+1];
        end
    end

    assign o_valid         = (r_cnt != 3'd0);
    assign o_token_kind    = r_res[0].kind;
    assign o_has_byte      = r_res[0].has_byte;
    assign o_payload_byte  = r_res[0].pbyte;
    assign o_token_done    = r_res[0].done;
    assign o_error_flag    = r_res[0].err;
    assign o_error_code    = r_res[0].code;
    assign o_line_number   = r_res[0].line;
    assign o_column_number = r_res[0].col;
    assign o_last_of_run   = (r_cnt == 3'd1);

    // Never accept while more than one result is pending.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_cnt <= 3'd1))
        else $error("byte accepted over a pending burst");

    // An error result always ends its run.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_flag) |-> o_last_of_run)
        else $error("error result not last of run");

    // Frozen lexer produces nothing from plain bytes.
    a_frozen_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_mode == jbt_pkg::M_FROZEN && !i_end_of_text) |=> (r_cnt == 3'd0))
        else $error("frozen lexer produced a result");

endmodule
